// ----- src/cds_pkg.sv -----
// calendar date step: shared word types, op codes, constants and calendar tables
// used by every stage module; depends on nothing
`default_nettype none

package cds_pkg;

	localparam logic [1:0] OP_ADD_YEAR   = 2'd0;
	localparam logic [1:0] OP_ADD_MONTH  = 2'd1;
	localparam logic [1:0] OP_ADD_DAY    = 2'd2;
	localparam logic [1:0] OP_NEXT_MON   = 2'd3;

	localparam logic [13:0] YEAR_MAX     = 14'd9999;
	localparam logic [8:0]  YEAR_BIAS    = 9'd400;

	// x / 100 == (x * RECIP100) >> RECIP100_SHIFT for every x below 2**15
	localparam logic [12:0] RECIP100       = 13'd5243;
	localparam int          RECIP100_SHIFT = 19;
	// x / 7 == (x * RECIP7) >> RECIP7_SHIFT for every x below 2**15
	localparam logic [15:0] RECIP7         = 16'd37450;
	localparam int          RECIP7_SHIFT   = 18;

	typedef struct packed {
		logic [1:0]  op;
		logic [13:0] in_year;
		logic [3:0]  in_month;
		logic [4:0]  in_day;
	} req_word_t;

	typedef struct packed {
		logic        date_ok;
		logic [2:0]  weekday;
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic        result_ok;
	} rsp_word_t;

	// date after decode: validity, month lengths and the weekday sum
	typedef struct packed {
		req_word_t   w;
		logic        date_ok;
		logic [4:0]  len;
		logic [4:0]  len_nm;
		logic [14:0] wsum;
	} prep_word_t;

	// date with weekday and the day advanced by the day-step count
	typedef struct packed {
		req_word_t   w;
		logic        date_ok;
		logic [4:0]  len;
		logic [4:0]  len_nm;
		logic [2:0]  wd;
		logic [5:0]  dd;
	} wday_word_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                       n = leap ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	// (3 * (mm + 1)) / 5 for the shifted month 3 to 14
	function automatic logic [3:0] month_term(input logic [3:0] mm);
		logic [3:0] t;
		case (mm)
			4'd3:          t = 4'd2;
			4'd4, 4'd5:    t = 4'd3;
			4'd6, 4'd7:    t = 4'd4;
			4'd8:          t = 4'd5;
			4'd9, 4'd10:   t = 4'd6;
			4'd11, 4'd12:  t = 4'd7;
			4'd13:         t = 4'd8;
			4'd14:         t = 4'd9;
			default:       t = 4'd0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ----- src/cds_prep.sv -----
// calendar date step, stages 1 and 2: century split, leap rule, date check
// and the weekday sum; depends on cds_pkg
`default_nettype none

module cds_prep import cds_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       up_valid,
	output logic            up_stall,
	input  wire req_word_t  up,
	output logic            dn_valid,
	input  wire logic       dn_stall,
	output prep_word_t      dn
);

	logic        vld_s1, vld_s2;
	logic        adv_s1, adv_s2;
	req_word_t   w_s1;
	logic [26:0] yprod_s1;
	logic [27:0] yyprod_s1;
	logic [14:0] yy_s1;
	logic [3:0]  mm_s1;
	prep_word_t  dn_s2;

	logic        early;
	logic [14:0] yy_c;
	logic [3:0]  mm_c;
	logic [7:0]  q_y, q_yy;
	logic [13:0] r_y;
	logic        leap;
	logic [3:0]  nm;
	logic [4:0]  len;
	logic [15:0] wsum;

	assign adv_s2   = !vld_s2 || !dn_stall;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign up_stall = !adv_s1;

	// january and february count as months 13 and 14 of the year before
	always_comb begin
		early = (up.in_month <= 4'd2);
		yy_c  = 15'(up.in_year) + 15'(YEAR_BIAS) - 15'(early);
		mm_c  = early ? (up.in_month + 4'd12) : up.in_month;
	end

	always_comb begin
		q_y  = yprod_s1[RECIP100_SHIFT+7:RECIP100_SHIFT];
		q_yy = yyprod_s1[RECIP100_SHIFT+7:RECIP100_SHIFT];
		r_y  = w_s1.in_year - 14'(q_y) * 14'd100;
		leap = (w_s1.in_year[1:0] == 2'd0) && ((r_y != 14'd0) || (q_y[1:0] == 2'd0));
		len  = month_len(w_s1.in_month, leap);
		nm   = (w_s1.in_month == 4'd12) ? 4'd1 : (w_s1.in_month + 4'd1);
		wsum = 16'(w_s1.in_day) + 16'({mm_s1, 1'b0}) + 16'(month_term(mm_s1))
			+ 16'(yy_s1) + 16'(yy_s1 >> 2) - 16'(q_yy) + 16'(q_yy >> 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= up_valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && up_valid) begin
			w_s1      <= up;
			yy_s1     <= yy_c;
			mm_s1     <= mm_c;
			yprod_s1  <= 27'(up.in_year) * 27'(RECIP100);
			yyprod_s1 <= 28'(yy_c) * 28'(RECIP100);
		end
		if (adv_s2 && vld_s1) begin
			dn_s2.w       <= w_s1;
			dn_s2.len     <= len;
			dn_s2.len_nm  <= month_len(nm, leap);
			dn_s2.wsum    <= wsum[14:0];
			dn_s2.date_ok <= (w_s1.in_year <= YEAR_MAX) && (w_s1.in_month >= 4'd1)
				&& (w_s1.in_month <= 4'd12) && (w_s1.in_day >= 5'd1)
				&& (w_s1.in_day <= len);
		end
	end

	assign dn_valid = vld_s2;
	assign dn       = dn_s2;

endmodule

`default_nettype wire

// ----- src/cds_wday.sv -----
// calendar date step, stages 3 and 4: weekday as the sum mod 7 and the
// advanced day for the day steps; depends on cds_pkg
`default_nettype none

module cds_wday import cds_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       up_valid,
	output logic            up_stall,
	input  wire prep_word_t up,
	output logic            dn_valid,
	input  wire logic       dn_stall,
	output wday_word_t      dn
);

	logic        vld_s3, vld_s4;
	logic        adv_s3, adv_s4;
	prep_word_t  p_s3;
	logic [30:0] prod_s3;
	wday_word_t  dn_s4;

	logic [11:0] q7;
	logic [14:0] r7;
	logic [2:0]  wd;
	logic [3:0]  n;

	assign adv_s4   = !vld_s4 || !dn_stall;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign up_stall = !adv_s3;

	always_comb begin
		q7 = prod_s3[RECIP7_SHIFT+11:RECIP7_SHIFT];
		r7 = p_s3.wsum - 15'(q7) * 15'd7;
		wd = r7[2:0] + 3'd1;
		// next monday lies 8 - weekday days ahead
		n  = (p_s3.w.op == OP_ADD_DAY) ? 4'd1 : (4'd8 - 4'(wd));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv_s3) vld_s3 <= up_valid;
			if (adv_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && up_valid) begin
			p_s3    <= up;
			prod_s3 <= 31'(up.wsum) * 31'(RECIP7);
		end
		if (adv_s4 && vld_s3) begin
			dn_s4.w       <= p_s3.w;
			dn_s4.date_ok <= p_s3.date_ok;
			dn_s4.len     <= p_s3.len;
			dn_s4.len_nm  <= p_s3.len_nm;
			dn_s4.wd      <= wd;
			dn_s4.dd      <= 6'(p_s3.w.in_day) + 6'(n);
		end
	end

	assign dn_valid = vld_s4;
	assign dn       = dn_s4;

endmodule

`default_nettype wire

// ----- src/cds_step.sv -----
// calendar date step, stage 5: applies the operation with month and year
// carry and year saturation into the output register; depends on cds_pkg
`default_nettype none

module cds_step import cds_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       up_valid,
	output logic            up_stall,
	input  wire wday_word_t up,
	output logic            dn_valid,
	input  wire logic       dn_stall,
	output rsp_word_t       dn
);

	logic       vld_s5;
	logic       adv_s5;
	rsp_word_t  dn_s5;
	rsp_word_t  res;

	logic        y_inc_ok;
	logic [13:0] y_next;
	logic        dec;

	assign adv_s5   = !vld_s5 || !dn_stall;
	assign up_stall = !adv_s5;

	always_comb begin
		y_inc_ok = (up.w.in_year != YEAR_MAX);
		y_next   = y_inc_ok ? (up.w.in_year + 14'd1) : up.w.in_year;
		dec      = (up.w.in_month == 4'd12);

		res.date_ok   = 1'b1;
		res.weekday   = up.wd;
		res.out_year  = up.w.in_year;
		res.out_month = up.w.in_month;
		res.out_day   = up.w.in_day;
		res.result_ok = 1'b1;

		case (up.w.op)
			OP_ADD_YEAR: begin
				// leap day rolls over to the first of march
				if (up.w.in_month == 4'd2 && up.w.in_day == 5'd29) begin
					res.out_month = 4'd3;
					res.out_day   = 5'd1;
				end
				res.out_year  = y_next;
				res.result_ok = y_inc_ok;
			end
			OP_ADD_MONTH: begin
				if (dec) begin
					res.out_month = 4'd1;
					res.out_year  = y_next;
					res.result_ok = y_inc_ok;
				end else begin
					res.out_month = up.w.in_month + 4'd1;
				end
				if (up.w.in_day > up.len_nm) res.result_ok = 1'b0;
			end
			default: begin
				if (up.dd > 6'(up.len)) begin
					res.out_day = 5'(up.dd - 6'(up.len));
					if (dec) begin
						res.out_month = 4'd1;
						res.out_year  = y_next;
						res.result_ok = y_inc_ok;
					end else begin
						res.out_month = up.w.in_month + 4'd1;
					end
				end else begin
					res.out_day = up.dd[4:0];
				end
			end
		endcase

		if (!up.date_ok) res = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv_s5) begin
			vld_s5 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5 && up_valid) dn_s5 <= res;
	end

	assign dn_valid = vld_s5;
	assign dn       = dn_s5;

endmodule

`default_nettype wire

// ----- src/calendar_date_step.sv -----
// calendar date step, top level: chains the decode, weekday and step stages
// depends on cds_pkg, cds_prep, cds_wday and cds_step
//
// usage
//   req channel: req_valid, req_stall, req word (op, year, month, day).
//   rsp channel: rsp_valid, rsp_stall, rsp word (date_ok, weekday, year,
//   month, day, result_ok). a word moves at a clock edge with valid high
//   and stall low.
//   one word enters per cycle while req_stall is low, through five register
//   stages; constant multiplies (by a reciprocal of 100 or 7) feed stages 1 and 3.
//   the stages advance on their own: while rsp is stalled, empty stages
//   still fill, and req_stall rises only when all five hold a word.
//   a stalled rsp word holds steady until taken.
//   reset empties every stage; nothing is lost or repeated under stalls.
//   an invalid date gives an all-zero rsp word.
`default_nettype none

module calendar_date_step import cds_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire req_word_t  req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_word_t       rsp
);

	logic        prep_valid, prep_stall;
	prep_word_t  prep;
	logic        wday_valid, wday_stall;
	wday_word_t  wday;

	cds_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (req_valid),
		.up_stall (req_stall),
		.up       (req),
		.dn_valid (prep_valid),
		.dn_stall (prep_stall),
		.dn       (prep)
	);

	cds_wday u_wday (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (prep_valid),
		.up_stall (prep_stall),
		.up       (prep),
		.dn_valid (wday_valid),
		.dn_stall (wday_stall),
		.dn       (wday)
	);

	cds_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (wday_valid),
		.up_stall (wday_stall),
		.up       (wday),
		.dn_valid (rsp_valid),
		.dn_stall (rsp_stall),
		.dn       (rsp)
	);

endmodule

`default_nettype wire

// ----- src/cds_checker.sv -----
// calendar date step: port-level checks on the result words over time
// depends on cds_pkg; bound to calendar_date_step below
`default_nettype none

module cds_checker import cds_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_stall,
	input wire logic       rsp_valid,
	input wire logic       rsp_stall,
	input wire rsp_word_t  rsp
);

	// an invalid date gives an all-zero word
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.date_ok) |-> (rsp == '0))
		else $error("invalid date word not all zero");

	// a valid date always carries a weekday of monday to sunday
	a_weekday_set: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.date_ok) |-> (rsp.weekday != 3'd0))
		else $error("valid date without weekday");

	// a good result is a valid date with a year in range, a month of 1 to 12 and a nonzero day
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.result_ok) |-> (rsp.date_ok && rsp.out_year <= YEAR_MAX
			&& rsp.out_month >= 4'd1 && rsp.out_month <= 4'd12 && rsp.out_day != 5'd0))
		else $error("good result outside calendar range");

	// req is pushed back only when the pipeline is full up to the output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("req stalled with empty output stage");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled rsp word changed");

endmodule

bind calendar_date_step cds_checker u_cds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
